// ===== hdl/smd_pkg.sv =====
package smd_pkg;

   // Operation codes carried on the request side
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam int VALUE_W     = 32;
   localparam int COUNT_OUT_W = 5;

   typedef logic [VALUE_W-1:0] value_type;

   // Per-cell controls for one cycle
   typedef struct packed {
      logic load;    // take the pushed value
      logic shift;   // take the upper neighbor's value
      logic tap;     // drive the held value onto the middle bus
   } cell_ctrl_type;

endpackage

// ===== hdl/stack_with_middle_delete_unit.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser: operation; tdata: push_value
// rsp      out        rsp_tvalid/rsp_tready  tdata: middle_value, middle_valid,
//                                            entry_count, refused
//
// A request updates the row of cells at its accept edge; the middle entry is
// gathered from the cells into the response register once the output is free.
// rsp_tvalid rises with that load; one request per cycle is sustained while
// responses are taken. reset (synchronous) empties the stack.
// A stalled response holds the next request back once one is in flight.
module stack_with_middle_delete_unit #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic [31:0] req_tdata,   // [31:0] push_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] middle_value, [32] middle_valid,
                                    // [37:33] entry_count, [38] refused, [39] zero
);
   import smd_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          pend_ff, pend_in;
   logic          refused_ff, refused_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   value_type     rsp_value_ff;
   logic          rsp_mvalid_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   logic          rsp_refused_ff;

   logic          req_fire, out_free, load_rsp;
   logic          full, empty;
   logic [CW-1:0] mid;
   logic          do_push, do_pop, do_del, refuse_now;

   cell_ctrl_type ctrl      [DEPTH];
   value_type     cell_val  [DEPTH];
   value_type     cell_tap  [DEPTH];
   value_type     middle;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign mid      = (count_ff - CW'(1)) >> 1;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign load_rsp = pend_ff && out_free;
   assign req_tready = !pend_ff || out_free;
   assign req_fire = req_tvalid && req_tready;

   // Decode the request into stack actions
   always_comb begin
      do_push    = 1'b0;
      do_pop     = 1'b0;
      do_del     = 1'b0;
      refuse_now = 1'b0;
      unique case (req_tuser)
         OP_PUSH: begin
            do_push    = req_fire && !full;
            refuse_now = full;
         end
         OP_POP: begin
            do_pop     = req_fire && !empty;
            refuse_now = empty;
         end
         OP_DELETE: begin
            do_del     = req_fire && !empty;
            refuse_now = empty;
         end
         OP_READ: begin
            refuse_now = 1'b0;
         end
         default: begin
            refuse_now = 1'b0;
         end
      endcase
   end

   // Advance the count
   always_comb begin
      count_in = count_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop || do_del) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Row of cells, each handing its value down on a middle delete
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign ctrl[i].load  = do_push && (count_ff == CW'(i));
      assign ctrl[i].shift = do_del && (CW'(i) >= mid) && (CW'(i + 1) < count_ff);
      assign ctrl[i].tap   = pend_ff && !empty && (CW'(i) == mid);

      if (i == DEPTH - 1) begin : g_top
         smd_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl[i]),
            .load_value  (req_tdata),
            .upper_value (cell_val[i]),
            .value       (cell_val[i]),
            .tap_value   (cell_tap[i])
         );
      end else begin : g_mid
         smd_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl[i]),
            .load_value  (req_tdata),
            .upper_value (cell_val[i+1]),
            .value       (cell_val[i]),
            .tap_value   (cell_tap[i])
         );
      end
   end

   // Gather the middle entry from the tapped cell
   always_comb begin
      middle = '0;
      for (int i = 0; i < DEPTH; i++) begin
         middle = middle | cell_tap[i];
      end
   end

   // Track the request in flight and the response handshake
   always_comb begin
      pend_in = pend_ff;
      if (req_fire) begin
         pend_in = 1'b1;
      end else if (load_rsp) begin
         pend_in = 1'b0;
      end
      refused_in = req_fire ? refuse_now : refused_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load_rsp) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // Hold the response payload until taken
   always_ff @(posedge clock) begin
      refused_ff <= refused_in;
      if (load_rsp) begin
         rsp_value_ff   <= middle;
         rsp_mvalid_ff  <= !empty;
         rsp_count_ff   <= COUNT_OUT_W'(count_ff);
         rsp_refused_ff <= refused_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_refused_ff, rsp_count_ff, rsp_mvalid_ff, rsp_value_ff};

endmodule

// ===== hdl/smd_cell.sv =====
module smd_cell (
   input  logic                  clock,
   input  smd_pkg::cell_ctrl_type ctrl,
   input  smd_pkg::value_type    load_value,
   input  smd_pkg::value_type    upper_value,
   output smd_pkg::value_type    value,
   output smd_pkg::value_type    tap_value
);
   import smd_pkg::*;

   value_type value_ff;
   value_type value_in;

   // Load a pushed value, or take the neighbor's value on a middle delete
   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = load_value;
      end else if (ctrl.shift) begin
         value_in = upper_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign tap_value = ctrl.tap ? value_ff : '0;

endmodule

// ===== tb/sv/stack_with_middle_delete_unit_test.sv =====
`timescale 1ns / 100ps

module stack_with_middle_delete_unit_test;
   import smd_pkg::*;

   localparam int STACK_DEPTH   = 16;
   localparam int CLOCK_HALF    = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int HOLD_CYCLES   = 300;
   localparam int IDLE_LIMIT    = 1000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int REPORT_LIMIT  = 10;

   // Receiver stall patterns
   localparam int STALL_NONE     = 0;
   localparam int STALL_RANDOM   = 1;
   localparam int STALL_PERIODIC = 2;

   // One response as seen on rsp_tdata, highest field first
   typedef struct packed {
      logic             refused;
      logic [4:0]       entry_count;
      logic             middle_valid;
      value_type        middle_value;
   } stack_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = OP_READ;     // [1:0] operation
   logic [31:0] req_tdata = '0;          // [31:0] push_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;               // [31:0] middle_value, [32] middle_valid,
                                         // [37:33] entry_count, [38] refused

   // Shadow stack that predicts every response
   value_type      shadow_cells [0:STACK_DEPTH-1];
   int unsigned    shadow_count = 0;
   stack_view_type pending_views [$];

   // Sender pacing
   bit gaps_on    = 1'b0;
   int max_gap    = 4;
   int burst_left = 0;

   // Receiver pacing
   int stall_mode    = STALL_NONE;
   int stall_phase   = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   // Bookkeeping
   int mismatches      = 0;
   int requests_sent   = 0;
   int views_checked   = 0;
   int full_refusals   = 0;
   int empty_refusals  = 0;
   int bottom_deletes  = 0;
   int peak_count      = 0;
   int idle_cycles     = 0;
   stack_view_type got_view;
   stack_view_type want_view;

   stack_with_middle_delete_unit #(.DEPTH(STACK_DEPTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #CLOCK_HALF clock = ~clock;

   // Apply one operation to the shadow stack and return the response it implies
   function automatic stack_view_type predict_stack(logic [1:0] op, value_type value);
      stack_view_type view;
      int unsigned    slot;
      view = '0;
      case (op)
         OP_PUSH: begin
            if (shadow_count >= STACK_DEPTH) begin
               view.refused = 1'b1;
               full_refusals++;
            end else begin
               shadow_cells[shadow_count] = value;
               shadow_count++;
            end
         end
         OP_POP: begin
            if (shadow_count == 0) begin
               view.refused = 1'b1;
               empty_refusals++;
            end else begin
               shadow_count--;
            end
         end
         OP_DELETE: begin
            if (shadow_count == 0) begin
               view.refused = 1'b1;
               empty_refusals++;
            end else begin
               if (shadow_count <= 2) bottom_deletes++;
               // close the gap left by the middle entry
               for (slot = (shadow_count - 1) / 2; slot + 1 < shadow_count; slot++)
                  shadow_cells[slot] = shadow_cells[slot + 1];
               shadow_count--;
            end
         end
         default: ;
      endcase
      if (shadow_count != 0) begin
         view.middle_value = shadow_cells[(shadow_count - 1) / 2];
         view.middle_valid = 1'b1;
      end
      view.entry_count = shadow_count[4:0];
      if (shadow_count > peak_count) peak_count = shadow_count;
      return view;
   endfunction

   // Push values skewed toward the sign boundary and the extremes
   function automatic value_type pick_value();
      case ($urandom_range(0, 5))
         0: return value_type'($urandom_range(0, 15)) - 32'd8;
         1: return 32'h8000_0000 | value_type'($urandom_range(0, 255));
         2: return 32'h7FFF_FF00 | value_type'($urandom_range(0, 255));
         3: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: return value_type'($urandom());
      endcase
   endfunction

   // Weighted choice of operation, weights given in percent
   function automatic logic [1:0] pick_operation(int push_pct, int pop_pct, int del_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < push_pct) return OP_PUSH;
      if (roll < push_pct + pop_pct) return OP_POP;
      if (roll < push_pct + pop_pct + del_pct) return OP_DELETE;
      return OP_READ;
   endfunction

   // Offer one request, wait for the accept edge, then pace the next one
   task automatic send_request(logic [1:0] op, value_type value);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_views.push_back(predict_stack(op, value));
      requests_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, max_gap);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
   endtask

   // Reset is held for a fixed number of cycles, once
   task automatic apply_reset();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
   endtask

   // Reads and removals on an empty stack
   task automatic test_empty_stack();
      send_request(OP_READ, 32'h1234_5678);
      send_request(OP_POP, 32'h0);
      send_request(OP_DELETE, 32'hFFFF_FFFF);
   endtask

   // Extreme values and deletes, including ones where the middle is the bottom entry
   task automatic test_small_deletes();
      send_request(OP_PUSH, 32'h8000_0000);
      send_request(OP_PUSH, 32'h7FFF_FFFF);
      send_request(OP_DELETE, 32'h0);
      send_request(OP_DELETE, 32'h0);
      send_request(OP_PUSH, 32'hFFFF_FFFF);
      send_request(OP_PUSH, 32'h0000_0000);
      send_request(OP_PUSH, 32'h0000_0001);
      send_request(OP_DELETE, 32'h0);
      send_request(OP_READ, 32'h0);
   endtask

   // Fill to the brim, push once more, then read
   task automatic test_full_stack();
      while (shadow_count < STACK_DEPTH) send_request(OP_PUSH, pick_value());
      send_request(OP_PUSH, 32'h5A5A_A5A5);
      send_request(OP_READ, 32'h0);
   endtask

   // Random operations with phases that fill, drain and hover
   task automatic test_random_mix(int item_total);
      int n;
      int phase;
      logic [1:0] op;
      gaps_on    = 1'b1;
      stall_mode = STALL_RANDOM;
      for (n = 0; n < item_total; n++) begin
         phase = (n / 100) % 3;
         if (n % 300 == 150) stall_mode = STALL_PERIODIC;
         if (n % 300 == 0) stall_mode = STALL_RANDOM;
         case (phase)
            0:       op = pick_operation(55, 15, 15);
            1:       op = pick_operation(15, 35, 35);
            default: op = pick_operation(30, 25, 25);
         endcase
         send_request(op, pick_value());
      end
   endtask

   // Hold the receiver off long enough that the block backs up on its input
   task automatic test_backpressure_fill(int item_total);
      int n;
      gaps_on    = 1'b0;
      stall_mode = STALL_NONE;
      hold_requests++;
      for (n = 0; n < item_total; n++)
         send_request(pick_operation(50, 20, 20), pick_value());
   endtask

   // Back-to-back requests with the receiver always ready
   task automatic test_streaming(int item_total);
      int n;
      gaps_on    = 1'b0;
      stall_mode = STALL_NONE;
      for (n = 0; n < item_total; n++)
         send_request(pick_operation(35, 25, 25), pick_value());
   endtask

   // Wait out outstanding responses and report
   task automatic finish_run();
      req_tvalid <= 1'b0;
      stall_mode = STALL_RANDOM;
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_views.size() != 0) mismatches += pending_views.size();
      $display("covered %0d requests, %0d responses, peak depth %0d", requests_sent,
               views_checked, peak_count);
      $display("refused %0d pushes when full, %0d removals when empty; %0d bottom deletes",
               full_refusals, empty_refusals, bottom_deletes);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   endtask

   initial begin
      apply_reset();
      test_empty_stack();
      test_small_deletes();
      test_full_stack();
      test_random_mix(900);
      test_backpressure_fill(80);
      test_streaming(200);
      finish_run();
   end

   // Drive rsp_tready: long hold-offs on demand, otherwise the current pattern
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (hold_requests != holds_served) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            STALL_RANDOM:   rsp_tready <= ($urandom_range(0, 9) >= 3);
            STALL_PERIODIC: rsp_tready <= ((stall_phase % 11) < 6);
            default:        rsp_tready <= 1'b1;
         endcase
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_view = rsp_tdata[38:0];
         if (pending_views.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected response %h with nothing pending", rsp_tdata);
         end else begin
            want_view = pending_views.pop_front();
            views_checked++;
            if (got_view.middle_value !== want_view.middle_value ||
                got_view.middle_valid !== want_view.middle_valid ||
                got_view.entry_count  !== want_view.entry_count  ||
                got_view.refused      !== want_view.refused      ||
                rsp_tdata[39] !== 1'b0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d: expected mid %h valid %b count %0d refused %b, got mid %h valid %b count %0d refused %b pad %b",
                           views_checked, want_view.middle_value, want_view.middle_valid,
                           want_view.entry_count, want_view.refused,
                           got_view.middle_value, got_view.middle_valid,
                           got_view.entry_count, got_view.refused, rsp_tdata[39]);
            end
         end
      end
   end

   // End the run if nothing moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles with %0d responses pending", idle_cycles,
                  pending_views.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
